// ===== design/aho_corasick_flat_scanner_top_macros.svh =====
// ----------------------------------------------------------------------------
// aho_corasick_flat_scanner_top_macros
// assertion macros used by the scanner controller
// ----------------------------------------------------------------------------
`ifndef AHO_CORASICK_FLAT_SCANNER_TOP_MACROS_SVH
`define AHO_CORASICK_FLAT_SCANNER_TOP_MACROS_SVH

// same-cycle implication, disabled during reset
`define ACFS_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("acfs check failed");

// next-cycle implication, disabled during reset
`define ACFS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("acfs check failed");

`endif

// ===== design/acfs_pkg.sv =====
// ----------------------------------------------------------------------------
// acfs_pkg
// sizes, action codes and controller/datapath interface types of the scanner
// ----------------------------------------------------------------------------
`default_nettype none

package acfs_pkg;

    localparam int NUM_STATES    = 1024;
    localparam int ALPHABET      = 256;
    localparam int PATTERN_SLOTS = 4096;
    localparam int MAX_PER_STATE = 64;

    localparam int STATE_W     = $clog2(NUM_STATES);
    localparam int SYM_W       = $clog2(ALPHABET);
    localparam int PAT_W       = $clog2(PATTERN_SLOTS);
    localparam int TRANS_DEPTH = NUM_STATES * ALPHABET;
    localparam int TRANS_AW    = STATE_W + SYM_W;

    localparam int ACT_W  = 3;
    localparam int BYTE_W = 8;
    localparam int POS_W  = 32;
    localparam int IDX_W  = 12;
    localparam int VAL_W  = 16;
    localparam int CNT_W  = 7;
    localparam int OUT_W  = PAT_W + CNT_W;

    localparam logic [ACT_W-1:0] ACT_SCAN    = 3'd0;
    localparam logic [ACT_W-1:0] ACT_TRANS   = 3'd1;
    localparam logic [ACT_W-1:0] ACT_OUTPUT  = 3'd2;
    localparam logic [ACT_W-1:0] ACT_PATTERN = 3'd3;
    localparam logic [ACT_W-1:0] ACT_RESTART = 3'd4;

    typedef struct packed {
        logic trans_we;
        logic out_we;
        logic pat_we;
        logic restart;
        logic scan_rd;
        logic state_ld;
        logic out_rd;
        logic list_ld;
        logic pat_next;
        logic res_ld;
    } t_cmd;

    typedef struct packed {
        logic count_zero;
        logic last;
        logic out_valid;
        logic out_taken;
    } t_sts;

endpackage

`default_nettype wire

// ===== design/acfs_ram.sv =====
// ----------------------------------------------------------------------------
// acfs_ram
// generic simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module acfs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== design/acfs_dp.sv =====
// ----------------------------------------------------------------------------
// acfs_dp
// scanner datapath: transition, output-list and pattern memories, dfa state,
// match list walk and result register
// ----------------------------------------------------------------------------
`default_nettype none

module acfs_dp (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire acfs_pkg::t_cmd              i_cmd,
    output acfs_pkg::t_sts                   o_sts,
    input  wire logic [acfs_pkg::BYTE_W-1:0] i_symbol,
    input  wire logic [acfs_pkg::POS_W-1:0]  i_position,
    input  wire logic [acfs_pkg::IDX_W-1:0]  i_table_index,
    input  wire logic [acfs_pkg::VAL_W-1:0]  i_table_value,
    input  wire logic [acfs_pkg::CNT_W-1:0]  i_table_count,
    input  wire logic                        i_stall,
    output logic                             o_valid,
    output logic      [acfs_pkg::POS_W-1:0]  o_match_end,
    output logic      [acfs_pkg::VAL_W-1:0]  o_pattern_number,
    output logic                             o_last_match
);

    logic [acfs_pkg::STATE_W-1:0] r_cur_state;
    logic [acfs_pkg::POS_W-1:0]   r_pos;
    logic [acfs_pkg::PAT_W-1:0]   r_ptr;
    logic [acfs_pkg::CNT_W-1:0]   r_remain;
    logic                         r_out_valid;
    logic [acfs_pkg::POS_W-1:0]   r_match_end;
    logic [acfs_pkg::VAL_W-1:0]   r_pattern_number;
    logic                         r_last_match;

    logic                          idx_ok;
    logic [acfs_pkg::CNT_W-1:0]    sat_count;
    logic [acfs_pkg::TRANS_AW-1:0] trans_waddr;
    logic [acfs_pkg::TRANS_AW-1:0] trans_raddr;
    logic [acfs_pkg::STATE_W-1:0]  trans_rdata;
    logic [acfs_pkg::OUT_W-1:0]    out_wdata;
    logic [acfs_pkg::OUT_W-1:0]    out_rdata;
    logic [acfs_pkg::PAT_W-1:0]    list_offset;
    logic [acfs_pkg::CNT_W-1:0]    list_count;
    logic [acfs_pkg::PAT_W-1:0]    pat_raddr;
    logic [acfs_pkg::VAL_W-1:0]    pat_rdata;
    logic                          taken;

    assign idx_ok    = 32'(i_table_index) < acfs_pkg::NUM_STATES;
    assign sat_count = (i_table_count > acfs_pkg::CNT_W'(acfs_pkg::MAX_PER_STATE))
                       ? acfs_pkg::CNT_W'(acfs_pkg::MAX_PER_STATE) : i_table_count;

    assign trans_waddr = {acfs_pkg::STATE_W'(i_table_index), acfs_pkg::SYM_W'(i_symbol)};
    assign trans_raddr = {r_cur_state, acfs_pkg::SYM_W'(i_symbol)};
    assign out_wdata   = {acfs_pkg::PAT_W'(i_table_value), sat_count};
    assign list_offset = out_rdata[acfs_pkg::OUT_W-1:acfs_pkg::CNT_W];
    assign list_count  = out_rdata[acfs_pkg::CNT_W-1:0];
    assign pat_raddr   = i_cmd.list_ld ? list_offset : r_ptr + acfs_pkg::PAT_W'(1);
    assign taken       = r_out_valid && !i_stall;

    acfs_ram #(
        .WIDTH (acfs_pkg::STATE_W),
        .DEPTH (acfs_pkg::TRANS_DEPTH)
    ) u_trans_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.trans_we && idx_ok),
        .i_waddr (trans_waddr),
        .i_wdata (acfs_pkg::STATE_W'(i_table_value)),
        .i_re    (i_cmd.scan_rd),
        .i_raddr (trans_raddr),
        .o_rdata (trans_rdata)
    );

    acfs_ram #(
        .WIDTH (acfs_pkg::OUT_W),
        .DEPTH (acfs_pkg::NUM_STATES)
    ) u_out_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.out_we && idx_ok),
        .i_waddr (acfs_pkg::STATE_W'(i_table_index)),
        .i_wdata (out_wdata),
        .i_re    (i_cmd.out_rd),
        .i_raddr (trans_rdata),
        .o_rdata (out_rdata)
    );

    acfs_ram #(
        .WIDTH (acfs_pkg::VAL_W),
        .DEPTH (acfs_pkg::PATTERN_SLOTS)
    ) u_pat_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.pat_we),
        .i_waddr (acfs_pkg::PAT_W'(i_table_index)),
        .i_wdata (i_table_value),
        .i_re    (i_cmd.list_ld || i_cmd.pat_next),
        .i_raddr (pat_raddr),
        .o_rdata (pat_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_state <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.restart) begin
                r_cur_state <= '0;
            end else if (i_cmd.state_ld) begin
                r_cur_state <= trans_rdata;
            end
            if (i_cmd.res_ld) begin
                r_out_valid <= 1'b1;
            end else if (taken) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_rd) begin
            r_pos <= i_position;
        end
        if (i_cmd.list_ld) begin
            r_ptr    <= list_offset;
            r_remain <= list_count;
        end else if (i_cmd.pat_next) begin
            r_ptr    <= pat_raddr;
            r_remain <= r_remain - acfs_pkg::CNT_W'(1);
        end
        if (i_cmd.res_ld) begin
            r_match_end      <= r_pos;
            r_pattern_number <= pat_rdata;
            r_last_match     <= (r_remain == acfs_pkg::CNT_W'(1));
        end
    end

    assign o_sts.count_zero = (list_count == '0);
    assign o_sts.last       = (r_remain == acfs_pkg::CNT_W'(1));
    assign o_sts.out_valid  = r_out_valid;
    assign o_sts.out_taken  = taken;

    assign o_valid          = r_out_valid;
    assign o_match_end      = r_match_end;
    assign o_pattern_number = r_pattern_number;
    assign o_last_match     = r_last_match;

endmodule

`default_nettype wire

// ===== design/acfs_ctrl.sv =====
// ----------------------------------------------------------------------------
// acfs_ctrl
// scanner controller: decodes input beats and sequences the scan, the
// output-list lookup and the match walk
// ----------------------------------------------------------------------------
`default_nettype none

`include "aho_corasick_flat_scanner_top_macros.svh"

module acfs_ctrl (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_valid,
    input  wire logic [acfs_pkg::ACT_W-1:0] i_action,
    input  wire logic                       i_emit,
    output logic                            o_stall,
    output acfs_pkg::t_cmd                  o_cmd,
    input  wire acfs_pkg::t_sts             i_sts
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_NEXT,
        S_OUT,
        S_PAT,
        S_EMIT
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_emit;
    logic   n_emit;
    logic   r_stall;
    logic   n_stall;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        n_emit  = r_emit;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    case (i_action)
                        acfs_pkg::ACT_SCAN: begin
                            o_cmd.scan_rd = 1'b1;
                            n_emit        = i_emit;
                            n_state       = S_NEXT;
                        end
                        acfs_pkg::ACT_TRANS:   o_cmd.trans_we = 1'b1;
                        acfs_pkg::ACT_OUTPUT:  o_cmd.out_we   = 1'b1;
                        acfs_pkg::ACT_PATTERN: o_cmd.pat_we   = 1'b1;
                        acfs_pkg::ACT_RESTART: o_cmd.restart  = 1'b1;
                        default: ;
                    endcase
                end
            end
            S_NEXT: begin
                o_cmd.state_ld = 1'b1;
                if (r_emit) begin
                    o_cmd.out_rd = 1'b1;
                    n_state      = S_OUT;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_OUT: begin
                if (i_sts.count_zero) begin
                    n_state = S_IDLE;
                end else begin
                    o_cmd.list_ld = 1'b1;
                    n_state       = S_PAT;
                end
            end
            S_PAT: begin
                o_cmd.res_ld = 1'b1;
                n_state      = S_EMIT;
            end
            S_EMIT: begin
                if (i_sts.out_taken) begin
                    if (i_sts.last) begin
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.pat_next = 1'b1;
                        n_state        = S_PAT;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
        n_stall = (n_state != S_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_emit  <= 1'b0;
            r_stall <= 1'b0;
        end else begin
            r_state <= n_state;
            r_emit  <= n_emit;
            r_stall <= n_stall;
        end
    end

    assign o_stall = r_stall;

    `ACFS_ASSERT_NEXT(a_scan_goes_next, i_clk, i_rst_n, o_cmd.scan_rd, r_state == S_NEXT && o_stall)
    `ACFS_ASSERT_NEXT(a_list_starts, i_clk, i_rst_n, r_state == S_OUT && !i_sts.count_zero, r_state == S_PAT)
    `ACFS_ASSERT_NOW(a_emit_holds_beat, i_clk, i_rst_n, r_state == S_EMIT, i_sts.out_valid)
    `ACFS_ASSERT_NOW(a_beat_only_emit, i_clk, i_rst_n, i_sts.out_valid, r_state == S_EMIT)

endmodule

`default_nettype wire

// ===== design/aho_corasick_flat_scanner_top.sv =====
// ----------------------------------------------------------------------------
// aho_corasick_flat_scanner_top
// multi-pattern byte scanner on a full dfa transition table with a flat
// per-state list of pattern ids
// ----------------------------------------------------------------------------
// One input beat is taken at a time. Table writes, restart and unused action
// codes are handled in the idle state without a stall. A scan beat reads the
// transition ram, then loads the new state from its registered read; with
// emit it then reads the output list of the new state, and when that state
// lists n pattern ids each id is one registered read of the pattern ram
// followed by a result beat held until it is taken. Tables are not cleared
// by reset; every entry must be written before a scan reads it.
`default_nettype none

module aho_corasick_flat_scanner_top (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_valid,
    output logic                             o_stall,
    input  wire logic [acfs_pkg::ACT_W-1:0]  i_action,
    input  wire logic [acfs_pkg::BYTE_W-1:0] i_symbol,
    input  wire logic                        i_emit,
    input  wire logic [acfs_pkg::POS_W-1:0]  i_position,
    input  wire logic [acfs_pkg::IDX_W-1:0]  i_table_index,
    input  wire logic [acfs_pkg::VAL_W-1:0]  i_table_value,
    input  wire logic [acfs_pkg::CNT_W-1:0]  i_table_count,
    output logic                             o_valid,
    input  wire logic                        i_stall,
    output logic      [acfs_pkg::POS_W-1:0]  o_match_end,
    output logic      [acfs_pkg::VAL_W-1:0]  o_pattern_number,
    output logic                             o_last_match
);

    acfs_pkg::t_cmd cmd;
    acfs_pkg::t_sts sts;

    acfs_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_action (i_action),
        .i_emit   (i_emit),
        .o_stall  (o_stall),
        .o_cmd    (cmd),
        .i_sts    (sts)
    );

    acfs_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_symbol         (i_symbol),
        .i_position       (i_position),
        .i_table_index    (i_table_index),
        .i_table_value    (i_table_value),
        .i_table_count    (i_table_count),
        .i_stall          (i_stall),
        .o_valid          (o_valid),
        .o_match_end      (o_match_end),
        .o_pattern_number (o_pattern_number),
        .o_last_match     (o_last_match)
    );

endmodule

`default_nettype wire
